// ===== rtl/bsr_pkg.sv =====
// Package for the byte stream reassembler: payload structs, ring entry type,
// sequencer state type and operation codes.
// No dependencies; every other file of the block refers to it by scoped names.
package bsr_pkg;

	// Operation codes carried in the operation field of an input item.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_PULL = 1'b1;

	// Width of the unassembled count field of a result item.
	localparam int unsigned COUNT_W = 11;

	typedef struct packed {
		logic        operation;
		logic [31:0] stream_index;
		logic [7:0]  data_byte;
		logic        has_byte;
		logic        end_of_stream;
	} bsr_in_t;

	typedef struct packed {
		logic               out_valid;
		logic [7:0]         out_byte;
		logic               stream_ended;
		logic [COUNT_W-1:0] unassembled_count;
	} bsr_out_t;

	// One ring entry: the held flag sits beside the stored byte.
	typedef struct packed {
		logic       held;
		logic [7:0] value;
	} bsr_entry_t;

	// Result handed from the sequencer to the output register.
	typedef struct packed {
		logic     load;
		bsr_out_t item;
	} bsr_ret_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_STORE,
		ST_WALK,
		ST_PULL
	} bsr_state_t;

endpackage

// ===== rtl/bsr_ring_mem.sv =====
// Ring memory of the reassembler: one write port and one read port, read data
// registered. Entry type from bsr_pkg.
module bsr_ring_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  bsr_pkg::bsr_entry_t wdata,
	input  logic [AW-1:0]       raddr,
	output bsr_pkg::bsr_entry_t rdata
);

	bsr_pkg::bsr_entry_t mem_q [DEPTH];
	bsr_pkg::bsr_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bsr_ctrl.sv =====
// Sequencer of the reassembler: stream indices, window checks, ring
// read-modify-write, contiguous-run walk and clearing pass.
// Uses bsr_pkg; drives the port of bsr_ring_mem.
module bsr_ctrl #(
	parameter int unsigned CAPACITY = 1024,
	parameter int unsigned AW       = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bsr_pkg::bsr_in_t    in_item,
	input  logic                out_free,
	output bsr_pkg::bsr_ret_t   ret,
	output logic                we,
	output logic [AW-1:0]       waddr,
	output bsr_pkg::bsr_entry_t wdata,
	output logic [AW-1:0]       raddr,
	input  bsr_pkg::bsr_entry_t rdata
);

	localparam int unsigned PW        = $clog2(CAPACITY + 1);
	localparam logic [AW:0]   CAP_W     = (AW + 1)'(CAPACITY);
	localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
	localparam logic [32:0]   CAP_X     = 33'(CAPACITY);

	bsr_pkg::bsr_state_t state_q, state_d;
	bsr_pkg::bsr_in_t    item_q, item_d;
	logic [31:0]   asm_q, asm_d;
	logic [31:0]   read_q, read_d;
	logic          eof_seen_q, eof_seen_d;
	logic [31:0]   eof_pos_q, eof_pos_d;
	logic [PW-1:0] pend_q, pend_d;
	logic [AW-1:0] asm_slot_q, asm_slot_d;
	logic [AW-1:0] read_slot_q, read_slot_d;
	logic [AW-1:0] slot_q, slot_d;
	logic [AW-1:0] clr_q, clr_d;

	// Window evaluation of the held push item.
	logic [31:0]   first;
	logic [32:0]   bound, seg_end;
	logic          keep, eof_rec, store, at_asm;
	logic [AW-1:0] off, slot_calc, asm_slot_inc, read_slot_inc;
	logic [AW:0]   slot_sum;
	logic [31:0]   pend_ext;

	always_comb begin
		bound    = {1'b0, read_q} + CAP_X;
		seg_end  = {1'b0, item_q.stream_index} + {32'd0, item_q.has_byte};
		first    = (item_q.stream_index > asm_q) ? item_q.stream_index : asm_q;
		keep     = ({1'b0, first} < bound) && ({1'b0, first} <= seg_end);
		eof_rec  = keep && item_q.end_of_stream && (seg_end <= bound);
		store    = keep && item_q.has_byte && (item_q.stream_index >= asm_q);
		at_asm   = item_q.stream_index == asm_q;
		// A stored position lies less than CAPACITY past the read index, so its
		// slot is the read slot plus the low bits of the distance, wrapped once.
		off      = item_q.stream_index[AW-1:0] - read_q[AW-1:0];
		slot_sum = {1'b0, read_slot_q} + {1'b0, off};
		slot_calc = (slot_sum >= CAP_W) ? AW'(slot_sum - CAP_W) : slot_sum[AW-1:0];
		asm_slot_inc  = (asm_slot_q == LAST_SLOT) ? '0 : asm_slot_q + 1'b1;
		read_slot_inc = (read_slot_q == LAST_SLOT) ? '0 : read_slot_q + 1'b1;
	end

	always_comb begin
		state_d     = state_q;
		item_d      = item_q;
		asm_d       = asm_q;
		read_d      = read_q;
		eof_seen_d  = eof_seen_q;
		eof_pos_d   = eof_pos_q;
		pend_d      = pend_q;
		asm_slot_d  = asm_slot_q;
		read_slot_d = read_slot_q;
		slot_d      = slot_q;
		clr_d       = clr_q;
		in_ready    = 1'b0;
		we          = 1'b0;
		waddr       = asm_slot_q;
		wdata       = '0;
		raddr       = read_slot_q;
		ret         = '0;

		unique case (state_q)
			bsr_pkg::ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				clr_d = clr_q + 1'b1;
				if (clr_q == LAST_SLOT) begin
					state_d = bsr_pkg::ST_IDLE;
				end
			end
			bsr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					item_d  = in_item;
					state_d = (in_item.operation == bsr_pkg::OP_PULL) ?
						bsr_pkg::ST_PULL : bsr_pkg::ST_EVAL;
				end
			end
			bsr_pkg::ST_EVAL: begin
				raddr = at_asm ? asm_slot_inc : slot_calc;
				if (eof_rec && (store || out_free)) begin
					eof_seen_d = 1'b1;
					eof_pos_d  = seg_end[31:0];
				end
				if (store && at_asm) begin
					// The byte closes the gap: it is assembled at once.
					we         = 1'b1;
					waddr      = asm_slot_q;
					wdata      = '{held: 1'b0, value: item_q.data_byte};
					asm_d      = asm_q + 32'd1;
					asm_slot_d = asm_slot_inc;
					state_d    = bsr_pkg::ST_WALK;
				end else if (store) begin
					slot_d  = slot_calc;
					state_d = bsr_pkg::ST_STORE;
				end else if (out_free) begin
					ret.load = 1'b1;
					state_d  = bsr_pkg::ST_IDLE;
				end
			end
			bsr_pkg::ST_STORE: begin
				raddr = slot_q;
				if (out_free) begin
					if (!rdata.held) begin
						we     = 1'b1;
						waddr  = slot_q;
						wdata  = '{held: 1'b1, value: item_q.data_byte};
						pend_d = pend_q + PW'(1);
					end
					ret.load = 1'b1;
					state_d  = bsr_pkg::ST_IDLE;
				end
			end
			bsr_pkg::ST_WALK: begin
				if (rdata.held) begin
					we         = 1'b1;
					waddr      = asm_slot_q;
					wdata      = '{held: 1'b0, value: rdata.value};
					asm_d      = asm_q + 32'd1;
					asm_slot_d = asm_slot_inc;
					raddr      = asm_slot_inc;
					if (pend_q != '0) begin
						pend_d = pend_q - PW'(1);
					end
				end else begin
					raddr = asm_slot_q;
					if (out_free) begin
						ret.load = 1'b1;
						state_d  = bsr_pkg::ST_IDLE;
					end
				end
			end
			bsr_pkg::ST_PULL: begin
				raddr = read_slot_q;
				if (out_free) begin
					if (read_q != asm_q) begin
						ret.item.out_valid = 1'b1;
						ret.item.out_byte  = rdata.value;
						read_d      = read_q + 32'd1;
						read_slot_d = read_slot_inc;
					end
					ret.load = 1'b1;
					state_d  = bsr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bsr_pkg::ST_IDLE;
			end
		endcase

		pend_ext = 32'(pend_d);
		ret.item.stream_ended = eof_seen_d && (asm_d == eof_pos_d) && (read_d == asm_d);
		ret.item.unassembled_count = pend_ext[bsr_pkg::COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsr_pkg::ST_CLEAR;
			asm_q       <= '0;
			read_q      <= '0;
			eof_seen_q  <= 1'b0;
			eof_pos_q   <= '0;
			pend_q      <= '0;
			asm_slot_q  <= '0;
			read_slot_q <= '0;
			clr_q       <= '0;
		end else begin
			state_q     <= state_d;
			asm_q       <= asm_d;
			read_q      <= read_d;
			eof_seen_q  <= eof_seen_d;
			eof_pos_q   <= eof_pos_d;
			pend_q      <= pend_d;
			asm_slot_q  <= asm_slot_d;
			read_slot_q <= read_slot_d;
			clr_q       <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		slot_q <= slot_d;
	end

endmodule

// ===== rtl/byte_stream_reassembler.sv =====
// Top level of the byte stream reassembler: sequencer, ring memory and the
// result register. Depends on bsr_pkg, bsr_ring_mem and bsr_ctrl.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_item  (bsr_pkg::bsr_in_t)
// res      output     res_valid / res_ready res_item (bsr_pkg::bsr_out_t)
//
// A pull moves from the idle state, in which its input transfer is taken, to the
// pull state, in which its result is loaded; a push that is dropped, or that
// only records the end of stream, has its result loaded in the evaluate state;
// a push stored beyond the assembled run goes on to the store state for the
// read-modify-write of its ring entry.
// A push that fills the gap goes on to the walk, which then assembles the held
// bytes, one ring entry per cycle.
// After reset a clearing pass over all CAPACITY entries wipes the held flags; no
// transfer is taken on the input channel until it ends.
// The result register lets the next input transfer be taken while a result
// waits; a finished item holds in its last step until that register is free.
module byte_stream_reassembler #(
	parameter int unsigned CAPACITY = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bsr_pkg::bsr_in_t  in_item,
	output logic              res_valid,
	input  logic              res_ready,
	output bsr_pkg::bsr_out_t res_item
);

	// Ring addresses are slot numbers, so they carry just enough bits for
	// CAPACITY entries; slots wrap explicitly rather than by masking.
	localparam int unsigned AW = $clog2(CAPACITY);

	bsr_pkg::bsr_ret_t   ret;
	bsr_pkg::bsr_entry_t wdata, rdata;
	logic                we;
	logic [AW-1:0]       waddr, raddr;
	logic                out_free;

	logic              res_valid_q;
	bsr_pkg::bsr_out_t res_item_q;

	// The sequencer may hand over a result whenever the register is empty or
	// its current content leaves in this very cycle.
	assign out_free = !res_valid_q || res_ready;

	bsr_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_free (out_free),
		.ret      (ret),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.raddr    (raddr),
		.rdata    (rdata)
	);

	bsr_ring_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ring (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Result register: valid is control state, the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ret.load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ret.load) begin
			res_item_q <= ret.item;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

// ===== test/tb_reassembly_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the byte stream reassembler testbench: a cycle-free predictor
// of the ring, window and end-of-stream logic, plus the queue of expected results.
// Depends on bsr_pkg for the payload structs and operation codes.
package tb_reassembly_pkg;

	localparam int unsigned RING_DEPTH = 1024;

	class reassembly_scoreboard;

		bit [7:0]          ring_bytes [RING_DEPTH];
		bit                held [RING_DEPTH];
		bit [31:0]         assembled_at;
		bit [31:0]         read_at;
		bit [31:0]         eof_at;
		bit                eof_known;
		int unsigned       held_beyond;
		bsr_pkg::bsr_out_t expected_results[$];
		int unsigned       mismatches;

		// Works out the result of one accepted input transfer and queues it.
		function void note_transfer(bsr_pkg::bsr_in_t it);
			bsr_pkg::bsr_out_t r;
			logic [32:0]       seg_end;
			logic [32:0]       bound;
			logic [32:0]       first;
			logic [32:0]       last;
			int unsigned       slot;
			r = '0;
			if (it.operation == bsr_pkg::OP_PUSH) begin
				seg_end = {1'b0, it.stream_index} + {32'd0, it.has_byte};
				bound = {1'b0, read_at} + 33'(RING_DEPTH);
				first = (it.stream_index > assembled_at) ? {1'b0, it.stream_index}
					: {1'b0, assembled_at};
				last = (seg_end < bound) ? seg_end : bound;
				if (first < bound && first <= last) begin
					if (it.end_of_stream && last == seg_end) begin
						eof_known = 1'b1;
						eof_at = seg_end[31:0];
					end
					if (first < last) begin
						slot = first[31:0] % RING_DEPTH;
						if (!held[slot]) begin
							ring_bytes[slot] = it.data_byte;
							held[slot] = 1'b1;
							held_beyond++;
						end
					end
					while (held[assembled_at % RING_DEPTH]) begin
						held[assembled_at % RING_DEPTH] = 1'b0;
						assembled_at++;
						if (held_beyond > 0)
							held_beyond--;
					end
				end
			end else if (read_at != assembled_at) begin
				r.out_valid = 1'b1;
				r.out_byte = ring_bytes[read_at % RING_DEPTH];
				read_at++;
			end
			r.stream_ended = eof_known && assembled_at == eof_at && read_at == assembled_at;
			r.unassembled_count = held_beyond[bsr_pkg::COUNT_W-1:0];
			expected_results = {expected_results, r};
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(bsr_pkg::bsr_out_t got);
			bsr_pkg::bsr_out_t want;
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: %p", got);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("out_valid", 32'(want.out_valid), 32'(got.out_valid));
			compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
			compare_field("stream_ended", 32'(want.stream_ended), 32'(got.stream_ended));
			compare_field("unassembled_count", 32'(want.unassembled_count),
				32'(got.unassembled_count));
		endfunction

	endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Top level of the byte stream reassembler testbench: clock, reset, the sender
// and receiver processes and the end-of-run verdict.
// Depends on bsr_pkg, tb_reassembly_pkg and the byte_stream_reassembler RTL.
module tb_top;

	localparam int unsigned RANDOM_ITEMS = 1830;
	localparam int unsigned CYCLE_LIMIT = 600000;
	// Every item yields a result, so once the queue is empty only a short
	// settling period is needed to catch any stray result transfer.
	localparam int unsigned DRAIN_CYCLES = 64;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	bsr_pkg::bsr_in_t  in_item;
	logic              res_valid;
	logic              res_ready;
	bsr_pkg::bsr_out_t res_item;

	tb_reassembly_pkg::reassembly_scoreboard sb;
	int unsigned cycles = 0;
	int unsigned items_offered = 0;
	int unsigned results_taken = 0;
	bit          sender_steady;
	bit          receiver_steady;

	byte_stream_reassembler #(.CAPACITY(tb_reassembly_pkg::RING_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: a healthy run finishes far inside this limit, even allowing for
	// the clearing pass after reset, the long receiver hold-off and every walk.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Offers one item on the input channel after a random idle gap, holds it
	// until the transfer happens and then hands it to the predictor. Valid is
	// only lowered when a gap follows, so back-to-back items never see valid
	// dropped and raised within the same time step.
	task automatic offer(bsr_pkg::bsr_in_t it);
		int unsigned gap;
		if (items_offered % 64 == 0)
			sender_steady = ($urandom_range(0, 3) == 0);
		gap = sender_steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_transfer(it);
		items_offered++;
	endtask

	task automatic push_byte(logic [31:0] idx, logic [7:0] value, logic has, logic eof);
		bsr_pkg::bsr_in_t it;
		it.operation = bsr_pkg::OP_PUSH;
		it.stream_index = idx;
		it.data_byte = value;
		it.has_byte = has;
		it.end_of_stream = eof;
		offer(it);
	endtask

	task automatic pull_byte();
		bsr_pkg::bsr_in_t it;
		it.operation = bsr_pkg::OP_PULL;
		it.stream_index = $urandom;
		it.data_byte = 8'($urandom);
		it.has_byte = 1'($urandom);
		it.end_of_stream = 1'($urandom);
		offer(it);
	endtask

	// Draws a random item around the current window. Most pushes land near the
	// assembled index so that gaps open and close often; some hit the window's
	// upper edge, some fall behind the assembled run, and the rest are noise
	// across the whole 32-bit position range. Pulls are favoured when a large
	// run of assembled bytes is waiting to be read.
	function automatic bsr_pkg::bsr_in_t draw_item();
		bsr_pkg::bsr_in_t it;
		int unsigned      pick;
		int unsigned      pull_share;
		int unsigned      back;
		pull_share = (sb.assembled_at - sb.read_at > 64) ? 60 : 40;
		it.operation = ($urandom_range(0, 99) < pull_share) ? bsr_pkg::OP_PULL
			: bsr_pkg::OP_PUSH;
		it.data_byte = 8'($urandom);
		it.has_byte = ($urandom_range(0, 19) != 0);
		it.end_of_stream = ($urandom_range(0, 24) == 0);
		pick = $urandom_range(0, 99);
		if (it.operation == bsr_pkg::OP_PULL || pick >= 90) begin
			it.stream_index = $urandom;
		end else if (pick < 50) begin
			it.stream_index = sb.assembled_at + $urandom_range(0, 15);
		end else if (pick < 70) begin
			it.stream_index = sb.assembled_at
				+ $urandom_range(0, sb.read_at + tb_reassembly_pkg::RING_DEPTH
				- sb.assembled_at + 3);
		end else if (pick < 80) begin
			back = $urandom_range(1, 8);
			it.stream_index = (sb.assembled_at >= back) ? sb.assembled_at - back : 0;
		end else begin
			it.stream_index = sb.read_at + tb_reassembly_pkg::RING_DEPTH - 1
				+ $urandom_range(0, 2);
		end
		return it;
	endfunction

	// Receiver: waits a random number of cycles before each result, with whole
	// stretches of no waiting, and once holds off for a long time so that the
	// result register and the sequencer back up and the input channel stalls.
	initial begin
		int unsigned gap;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (results_taken % 64 == 0)
				receiver_steady = ($urandom_range(0, 3) == 0);
			gap = receiver_steady ? 0 : $urandom_range(0, 12);
			if (results_taken == 600)
				gap = 400;
			if (gap > 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid)
				@(posedge clk);
			sb.check_result(res_item);
			results_taken++;
		end
	end

	// Sender and verdict.
	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening from the reset state: empty pull, empty segment,
		// out-of-order arrival, duplicate of a held byte, the gap filling and
		// the walk, a segment wholly behind the assembled run (its eof is
		// lost), an empty segment recording eof at the assembled index, the
		// stream end, far-off segments, both sides of the window's upper edge
		// and a later eof overwriting the first.
		pull_byte();
		push_byte(32'd0, 8'h00, 1'b0, 1'b0);
		push_byte(32'd2, 8'hAA, 1'b1, 1'b0);
		push_byte(32'd2, 8'h55, 1'b1, 1'b0);
		push_byte(32'd1, 8'hFF, 1'b1, 1'b0);
		push_byte(32'd0, 8'h00, 1'b1, 1'b0);
		push_byte(32'd1, 8'h11, 1'b1, 1'b1);
		push_byte(32'd3, 8'h00, 1'b0, 1'b1);
		repeat (4) pull_byte();
		push_byte(32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1);
		push_byte(32'h8000_0000, 8'h5A, 1'b0, 1'b1);
		push_byte(32'd1026, 8'hC3, 1'b1, 1'b1);
		push_byte(32'd1027, 8'h3C, 1'b1, 1'b0);
		push_byte(32'd3, 8'h7E, 1'b1, 1'b0);
		push_byte(32'd4, 8'h00, 1'b0, 1'b1);
		pull_byte();

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			// Midway the sender goes quiet until every result has come back.
			if (n == 1200) begin
				in_valid <= 1'b0;
				do
					@(posedge clk);
				while (sb.expected_results.size() != 0);
			end
			offer(draw_item());
		end
		in_valid <= 1'b0;

		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
